// ===== src/tcw_pkg.sv =====
package tcw_pkg;

  localparam int DEF_COLS = 80;
  localparam int DEF_ROWS = 25;
  localparam int CELL_W   = 16;

  localparam logic [1:0] FUNC_PUT   = 2'd0;
  localparam logic [1:0] FUNC_CLEAR = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  localparam logic [7:0] CHAR_NEWLINE      = 8'd10;
  localparam logic [7:0] ATTR_BRIGHT_WHITE = 8'h0F;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_PUT,
    OP_NEWLINE,
    OP_CLEAR,
    OP_READ
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] ch;
  } cmd_t;

  typedef struct packed {
    logic        scrolled;
    logic [4:0]  cur_row;
    logic [6:0]  cur_col;
    logic [15:0] cell_data;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_ZERO,
    ST_DONE
  } state_t;

endpackage

// ===== src/tcw_ram.sv =====
module tcw_ram #(
  parameter int WIDTH = tcw_pkg::CELL_W,
  parameter int DEPTH = tcw_pkg::DEF_COLS * tcw_pkg::DEF_ROWS
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/tcw_front.sv =====
module tcw_front #(
  parameter int COLS = tcw_pkg::DEF_COLS,
  parameter int ROWS = tcw_pkg::DEF_ROWS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_func,
  input  logic [7:0]                    in_char,
  input  logic [4:0]                    in_row,
  input  logic [6:0]                    in_col,
  output logic                          cmd_valid,
  output tcw_pkg::cmd_t                 cmd,
  output logic [$clog2(ROWS*COLS)-1:0]  cmd_addr,
  input  logic                          cmd_pop
);

  import tcw_pkg::*;

  localparam int AW = $clog2(ROWS * COLS);

  cmd_t             new_cmd;
  logic [AW-1:0]    new_addr;
  logic [31:0]      full_addr;
  logic             in_range;
  logic             push;

  cmd_t             q_cmd  [QDEPTH];
  logic [AW-1:0]    q_addr [QDEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QPTR_W:0]   count;

  always_comb begin
    in_range  = (32'(in_row) < ROWS) && (32'(in_col) < COLS);
    full_addr = 32'(in_row) * COLS + 32'(in_col);
    new_addr  = AW'(full_addr);
    new_cmd.ch = in_char;
    unique case (in_func)
      FUNC_PUT:   new_cmd.op = (in_char == CHAR_NEWLINE) ? OP_NEWLINE : OP_PUT;
      FUNC_CLEAR: new_cmd.op = OP_CLEAR;
      FUNC_READ:  new_cmd.op = in_range ? OP_READ : OP_NOP;
      default:    new_cmd.op = OP_NOP;
    endcase
  end

  assign in_ready  = (count != (QPTR_W+1)'(QDEPTH));
  assign push      = in_valid && in_ready;
  assign cmd_valid = (count != '0);
  assign cmd       = q_cmd[rptr];
  assign cmd_addr  = q_addr[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + QPTR_W'(1);
      end
      if (cmd_pop) begin
        rptr <= rptr + QPTR_W'(1);
      end
      case ({push, cmd_pop})
        2'b10:   count <= count + (QPTR_W+1)'(1);
        2'b01:   count <= count - (QPTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_cmd[wptr]  <= new_cmd;
      q_addr[wptr] <= new_addr;
    end
  end

endmodule

// ===== src/tcw_back.sv =====
module tcw_back #(
  parameter int COLS = tcw_pkg::DEF_COLS,
  parameter int ROWS = tcw_pkg::DEF_ROWS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  input  tcw_pkg::cmd_t                 cmd,
  input  logic [$clog2(ROWS*COLS)-1:0]  cmd_addr,
  output logic                          cmd_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output tcw_pkg::res_t                 out_res
);

  import tcw_pkg::*;

  localparam int N  = ROWS * COLS;
  localparam int AW = $clog2(N);
  localparam int CW = $clog2(COLS);
  localparam int RW = $clog2(ROWS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(N - 1);
  localparam logic [AW-1:0] COPY_END  = AW'((ROWS - 1) * COLS);

  state_t state;
  state_t state_next;

  logic [CW-1:0]     cursor_col;
  logic [RW-1:0]     cursor_row;
  logic [AW-1:0]     sa;
  logic [AW-1:0]     wr_addr;
  logic              wr_pend;
  logic [CELL_W-1:0] res_data;
  logic              res_scr;

  logic [AW-1:0]     cur_addr;
  logic              col_wrap;
  logic              row_last;
  logic              adv_row;
  logic              need_scroll;
  logic              scan_rd;
  logic              out_free;
  logic              out_load;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (N)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    cur_addr    = AW'(cursor_row) * AW'(COLS) + AW'(cursor_col);
    col_wrap    = (cursor_col == CW'(COLS - 1));
    row_last    = (cursor_row == RW'(ROWS - 1));
    adv_row     = (cmd.op == OP_NEWLINE) || ((cmd.op == OP_PUT) && col_wrap);
    need_scroll = adv_row && row_last;
    scan_rd     = (sa != COPY_END);
    out_free    = !out_valid || out_ready;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.op) inside
            OP_PUT, OP_NEWLINE: state_next = need_scroll ? ST_SCROLL : ST_DONE;
            OP_CLEAR:           state_next = ST_ZERO;
            OP_READ:            state_next = ST_READ;
            default:            state_next = ST_DONE;
          endcase
        end
      end
      ST_READ:   state_next = ST_DONE;
      ST_SCROLL: state_next = scan_rd ? ST_SCROLL : ST_ZERO;
      ST_ZERO:   state_next = (sa == LAST_ADDR) ? ST_DONE : ST_ZERO;
      ST_DONE:   state_next = out_free ? ST_IDLE : ST_DONE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop   = 1'b0;
    out_load  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = sa;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = cmd_addr;
    unique case (state)
      ST_IDLE: begin
        cmd_pop   = cmd_valid;
        ram_we    = cmd_valid && (cmd.op == OP_PUT);
        ram_waddr = cur_addr;
        ram_wdata = {ATTR_BRIGHT_WHITE, cmd.ch};
        ram_re    = cmd_valid && (cmd.op == OP_READ);
      end
      ST_SCROLL: begin
        ram_re    = scan_rd;
        ram_raddr = sa + AW'(COLS);
        ram_we    = wr_pend;
        ram_waddr = wr_addr;
        ram_wdata = ram_rdata;
      end
      ST_ZERO: begin
        ram_we = 1'b1;
      end
      ST_DONE: begin
        out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cursor_col <= '0;
      cursor_row <= '0;
      out_valid  <= 1'b0;
      wr_pend    <= 1'b0;
    end else begin
      state   <= state_next;
      wr_pend <= (state == ST_SCROLL) && scan_rd;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd_pop && ((cmd.op == OP_PUT) || (cmd.op == OP_NEWLINE))) begin
        if (adv_row) begin
          cursor_col <= '0;
          if (!row_last) begin
            cursor_row <= cursor_row + RW'(1);
          end
        end else begin
          cursor_col <= cursor_col + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    wr_addr <= sa;
    unique case (state)
      ST_IDLE: begin
        sa       <= '0;
        res_data <= '0;
        res_scr  <= need_scroll && ((cmd.op == OP_PUT) || (cmd.op == OP_NEWLINE));
      end
      ST_READ: begin
        res_data <= ram_rdata;
      end
      ST_SCROLL: begin
        if (scan_rd) begin
          sa <= sa + AW'(1);
        end
      end
      ST_ZERO: begin
        if (sa != LAST_ADDR) begin
          sa <= sa + AW'(1);
        end
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_res.cell_data <= res_data;
      out_res.cur_col   <= 7'(cursor_col);
      out_res.cur_row   <= 5'(cursor_row);
      out_res.scrolled  <= res_scr;
    end
  end

endmodule

// ===== src/text_console_writer_top.sv =====
// Channel  Dir  Handshake          Payload
// s        in   s_tvalid/s_tready  s_tuser: func; s_tdata: char_code, read_row, read_col
// m        out  m_tvalid/m_tready  m_tdata: cell_data, cur_col, cur_row, scrolled
//
// Put, newline and unused codes pass from idle to done in the sequencer; read adds a read state.
// Scroll adds a pipelined copy through the one-read,
// one-write cell memory, then a zero sweep of the bottom row.
// Clear writes zeros to every cell, one cell written per cycle.
// Reset homes the cursor; cells are undefined until written, no clearing pass.
// A two-item queue parts front from back; the result register holds on m_tready low.
module text_console_writer_top #(
  parameter int COLS = tcw_pkg::DEF_COLS,
  parameter int ROWS = tcw_pkg::DEF_ROWS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // char_code[7:0], read_row[12:8], read_col[19:13]
  input  logic [1:0]  s_tuser,   // func[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // cell_data[15:0], cur_col[22:16], cur_row[27:23],
                                 // scrolled[28]
);

  import tcw_pkg::*;

  localparam int AW = $clog2(ROWS * COLS);

  logic          cmd_valid;
  cmd_t          cmd;
  logic [AW-1:0] cmd_addr;
  logic          cmd_pop;
  res_t          out_res;

  tcw_front #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_func   (s_tuser),
    .in_char   (s_tdata[7:0]),
    .in_row    (s_tdata[12:8]),
    .in_col    (s_tdata[19:13]),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_addr  (cmd_addr),
    .cmd_pop   (cmd_pop)
  );

  tcw_back #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_addr  (cmd_addr),
    .cmd_pop   (cmd_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  assign m_tdata = {3'b000, out_res};

`ifndef SYNTH
  assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> cmd_valid)
    else $error("back popped an empty queue");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((32'(out_res.cur_col) < COLS) && (32'(out_res.cur_row) < ROWS)))
    else $error("cursor outside grid");

  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_res.scrolled) |->
      ((out_res.cur_col == 7'd0) && (out_res.cur_row == 5'(ROWS - 1))))
    else $error("scroll left cursor off bottom row start");
`endif

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import tcw_pkg::*;

  localparam int COLS = DEF_COLS;
  localparam int ROWS = DEF_ROWS;
  localparam int CELLS = ROWS * COLS;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int ITEM_TARGET = 450;
  localparam int DRAIN_AT = 300;
  localparam int HOLD_AT = 150;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 20;
  localparam int STALL_LIMIT = 20000;

  class console_shadow;
    logic [15:0] cells [CELLS];
    bit known [CELLS];
    int col_pos;
    int row_pos;
    res_t status_q [$];
    int errors;
    int seen;

    function new();
      col_pos = 0;
      row_pos = 0;
      errors = 0;
      seen = 0;
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
    endtask

    function bit next_line();
      if (row_pos + 1 >= ROWS) begin
        for (int i = 0; i < CELLS - COLS; i++) begin
          cells[i] = cells[i + COLS];
          known[i] = known[i + COLS];
        end
        for (int i = CELLS - COLS; i < CELLS; i++) begin
          cells[i] = '0;
          known[i] = 1'b1;
        end
        row_pos = ROWS - 1;
        return 1'b1;
      end
      row_pos++;
      return 1'b0;
    endfunction

    function void log_request(logic [1:0] f, logic [7:0] ch, logic [4:0] rr, logic [6:0] rc);
      res_t want;
      want = '0;
      case (f)
        FUNC_PUT: begin
          if (ch == CHAR_NEWLINE) begin
            col_pos = 0;
            want.scrolled = next_line();
          end else begin
            cells[row_pos * COLS + col_pos] = {ATTR_BRIGHT_WHITE, ch};
            known[row_pos * COLS + col_pos] = 1'b1;
            col_pos++;
            if (col_pos >= COLS) begin
              col_pos = 0;
              want.scrolled = next_line();
            end
          end
        end
        FUNC_CLEAR: begin
          for (int i = 0; i < CELLS; i++) begin
            cells[i] = '0;
            known[i] = 1'b1;
          end
        end
        FUNC_READ: begin
          if (rr < ROWS && rc < COLS) want.cell_data = cells[rr * COLS + rc];
        end
        default: ;
      endcase
      want.cur_col = col_pos[6:0];
      want.cur_row = row_pos[4:0];
      status_q.push_back(want);
    endfunction

    task check_status(logic [31:0] word);
      res_t got;
      res_t want;
      got = res_t'(word[28:0]);
      seen++;
      if (status_q.size() == 0) begin
        report($sformatf("result %0d with nothing pending: %h", seen, word));
        return;
      end
      want = status_q.pop_front();
      if (got.cell_data !== want.cell_data)
        report($sformatf("result %0d cell_data %h, want %h", seen, got.cell_data,
                         want.cell_data));
      if (got.cur_col !== want.cur_col)
        report($sformatf("result %0d cur_col %0d, want %0d", seen, got.cur_col, want.cur_col));
      if (got.cur_row !== want.cur_row)
        report($sformatf("result %0d cur_row %0d, want %0d", seen, got.cur_row, want.cur_row));
      if (got.scrolled !== want.scrolled)
        report($sformatf("result %0d scrolled %b, want %b", seen, got.scrolled,
                         want.scrolled));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [23:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [31:0] m_tdata;

  console_shadow sb = new();
  int sent = 0;
  bit src_steady = 1'b0;
  bit dst_steady = 1'b0;
  int stall_cycles = 0;

  text_console_writer_top #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_request(input logic [1:0] f, input logic [7:0] ch,
                              input logic [4:0] rr, input logic [6:0] rc);
    int gap;
    if ($urandom_range(0, 39) == 0) src_steady = !src_steady;
    gap = src_steady ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= f;
    s_tdata <= {4'b0000, rc, rr, ch};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.log_request(f, ch, rr, rc);
    if (f != FUNC_UNUSED) sent++;
  endtask

  task automatic send_put(input logic [7:0] ch);
    send_request(FUNC_PUT, ch, 5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)));
  endtask

  task automatic send_read(input int r, input int c);
    send_request(FUNC_READ, 8'($urandom_range(0, 255)), r[4:0], c[6:0]);
  endtask

  task automatic send_read_any();
    int r;
    int c;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      r = sb.row_pos;
      c = $urandom_range(0, COLS - 1);
    end else if (pick < 75) begin
      r = $urandom_range(0, ROWS - 1);
      c = $urandom_range(0, COLS - 1);
    end else begin
      r = $urandom_range(0, 31);
      c = $urandom_range(0, 127);
    end
    if (r < ROWS && c < COLS && !sb.known[r * COLS + c]) r = $urandom_range(ROWS, 31);
    send_read(r, c);
  endtask

  task automatic send_clear();
    send_request(FUNC_CLEAR, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
                 7'($urandom_range(0, 127)));
  endtask

  initial begin
    int gap;
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) dst_steady = !dst_steady;
      gap = dst_steady ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      sb.check_status(m_tdata);
      if (sb.seen == HOLD_AT) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
    end
  end

  initial begin
    int kind;
    int len;
    int n;
    bit drained;
    logic [7:0] ch;
    drained = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_put(8'h41);
    send_read(0, 0);
    send_request(FUNC_UNUSED, 8'hFF, 5'h1F, 7'h7F);
    send_clear();
    send_read(0, 0);
    send_read(ROWS - 1, COLS - 1);
    send_put(8'h00);
    send_put(8'hFF);
    send_put(8'hAA);
    send_put(8'h55);
    send_read(0, 1);
    send_read(0, 2);
    send_read(0, 4);
    send_put(CHAR_NEWLINE);
    send_read(ROWS, 0);
    send_read(0, COLS);
    send_read(31, 127);
    send_read(21, 42);
    send_put(CHAR_NEWLINE);
    send_put(8'h7A);
    send_read(2, 0);
    send_request(FUNC_UNUSED, 8'h00, 5'h00, 7'h00);

    while (sent < ITEM_TARGET) begin
      if (!drained && sent >= DRAIN_AT) begin
        s_tvalid <= 1'b0;
        while (sb.status_q.size() != 0) @(posedge clk);
        @(posedge clk);
        drained = 1'b1;
      end
      kind = $urandom_range(0, 99);
      if (kind < 50) begin
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 100) : $urandom_range(1, 12);
        for (int i = 0; i < len; i++) begin
          ch = ($urandom_range(0, 19) == 0) ? CHAR_NEWLINE : 8'($urandom_range(0, 255));
          send_put(ch);
        end
        if ($urandom_range(0, 9) < 6) send_put(CHAR_NEWLINE);
      end else if (kind < 65) begin
        n = $urandom_range(1, 4);
        repeat (n) send_put(CHAR_NEWLINE);
      end else if (kind < 85) begin
        n = $urandom_range(1, 4);
        repeat (n) send_read_any();
      end else if (kind < 89) begin
        send_clear();
      end else if (kind < 93) begin
        send_request(FUNC_UNUSED, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
                     7'($urandom_range(0, 127)));
      end else begin
        case ($urandom_range(0, 3))
          0: send_put(8'($urandom_range(0, 255)));
          1: send_clear();
          2: send_read_any();
          default: send_request(FUNC_UNUSED, 8'($urandom_range(0, 255)),
                                5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)));
        endcase
      end
    end

    s_tvalid <= 1'b0;
    while (sb.status_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.status_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/tcw_pkg.sv
src/tcw_ram.sv
src/tcw_front.sv
src/tcw_back.sv
src/text_console_writer_top.sv
tb/testbench.sv
